FILE: hdl/aavr_pkg.sv
// Shared types, constants and helpers for the axis-angle vector rotation block.
package aavr_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int MID_DEPTH        = 4;
    localparam int OUT_DEPTH        = 4;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30         = 34'sd1073741824;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_axis;

    // CORDIC working set, carried down the stage chain
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
        t_vec               vec;
        t_axis              axis;
    } t_cord;

    // transaction handed from front to back: vector, axis, cos and sin in Q4.30
    typedef struct packed {
        t_vec               vec;
        t_axis              axis;
        logic signed [33:0] c;
        logic signed [33:0] s;
    } t_mid;

    typedef struct packed {
        t_vec vec;
        logic sat;
    } t_res;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051D;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2E;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat_coef(input logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > 39'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -39'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/axis_angle_vector_rotation.sv
// Top level: axis-angle vector rotation, front/back pipelines joined by queues.
//
// Input side is a queue write port: a transaction is taken at a clock edge
// with push high and full low. It carries a Q16.16 vector, a Q2.14 unit axis
// and a 16-bit binary angle. Result side is a queue read port: while empty is
// low the oldest rotated vector (Q16.16, saturated flag) is on the o_ ports,
// and it leaves at an edge with pop high.
// Throughput is one transaction per cycle while no queue is full. The front
// runs one CORDIC step per stage, the back is a five-stage multiply
// pipeline, and each queue registers what it takes. The front stalls only
// when the middle queue fills, the back only when the result queue fills, so
// a stalled receiver backs up through the queues and then raises full. Reset
// empties both queues and clears every valid bit; no transaction in flight
// survives it.
module axis_angle_vector_rotation import aavr_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    input  logic        [15:0] i_turn_angle,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_saturated
);
    t_vec  in_vec;
    t_axis in_axis;
    logic  f_valid, mid_full, mid_empty, mid_pop;
    t_mid  f_item, mid_item;
    logic  b_valid, out_full;
    t_res  b_res, out_res;

    assign in_vec.x  = i_in_x;
    assign in_vec.y  = i_in_y;
    assign in_vec.z  = i_in_z;
    assign in_axis.x = i_axis_x;
    assign in_axis.y = i_axis_y;
    assign in_axis.z = i_axis_z;

    aavr_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_vec   (in_vec),
        .i_axis  (in_axis),
        .i_turn  (i_turn_angle),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_full  (mid_full)
    );

    aavr_fifo #(.WIDTH($bits(t_mid)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !mid_full),
        .i_data  (f_item),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_empty (mid_empty)
    );

    aavr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!mid_empty),
        .i_item  (mid_item),
        .o_pop   (mid_pop),
        .o_valid (b_valid),
        .o_res   (b_res),
        .i_full  (out_full)
    );

    aavr_fifo #(.WIDTH($bits(t_res)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid && !out_full),
        .i_data  (b_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_out_x     = out_res.vec.x;
    assign o_out_y     = out_res.vec.y;
    assign o_out_z     = out_res.vec.z;
    assign o_saturated = out_res.sat;
endmodule

FILE: hdl/aavr_fifo.sv
// Small register queue with push/full and pop/empty sides.
module aavr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(wr_en) - (PW+1)'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

FILE: hdl/aavr_front.sv
// Front end: takes transactions, folds the angle and runs the CORDIC stage chain.
module aavr_front import aavr_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_vec        i_vec,
    input  t_axis       i_axis,
    input  logic [15:0] i_turn,
    output logic        o_valid,
    output t_mid        o_item,
    input  logic        i_full
);
    localparam int NS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    t_cord r_cd [NS+1];
    t_cord n_cd [NS+1];
    logic  r_cv [NS+1];
    t_mid  r_o;
    logic  r_ov;
    logic  en;
    logic  fold;

    assign en      = !i_full;
    assign o_full  = !en;
    assign o_valid = r_ov;
    assign o_item  = r_o;

    // angles outside [-90, +90) degrees get a half turn added and results negated
    assign fold = i_turn[15] ^ i_turn[14];

    always_comb begin
        n_cd[0].x    = CORDIC_GAIN_Q30;
        n_cd[0].y    = '0;
        n_cd[0].z    = 34'($signed({i_turn[15] ^ fold, i_turn[14:0], 16'h0000}));
        n_cd[0].flip = fold;
        n_cd[0].vec  = i_vec;
        n_cd[0].axis = i_axis;
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        always_comb begin
            n_cd[k+1] = r_cd[k];
            if (!r_cd[k].z[33]) begin
                n_cd[k+1].x = r_cd[k].x - (r_cd[k].y >>> k);
                n_cd[k+1].y = r_cd[k].y + (r_cd[k].x >>> k);
                n_cd[k+1].z = r_cd[k].z - $signed({2'b00, atan_turn(k)});
            end else begin
                n_cd[k+1].x = r_cd[k].x + (r_cd[k].y >>> k);
                n_cd[k+1].y = r_cd[k].y - (r_cd[k].x >>> k);
                n_cd[k+1].z = r_cd[k].z + $signed({2'b00, atan_turn(k)});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_cv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_push;
            for (int k = 0; k < NS; k++) begin
                r_cv[k+1] <= r_cv[k];
            end
            r_ov <= r_cv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= NS; k++) begin
                r_cd[k] <= n_cd[k];
            end
            r_o.vec  <= r_cd[NS].vec;
            r_o.axis <= r_cd[NS].axis;
            r_o.c    <= r_cd[NS].flip ? -r_cd[NS].x : r_cd[NS].x;
            r_o.s    <= r_cd[NS].flip ? -r_cd[NS].y : r_cd[NS].y;
        end
    end
endmodule

FILE: hdl/aavr_back.sv
// Back end: builds the rotation matrix and applies it to the vector.
module aavr_back import aavr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_mid i_item,
    output logic o_pop,
    output logic o_valid,
    output t_res o_res,
    input  logic i_full
);
    // axis product order: xx, xy, xz, yy, yz, zz
    localparam int P_XX = 0, P_XY = 1, P_XZ = 2, P_YY = 3, P_YZ = 4, P_ZZ = 5;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic signed [31:0] r_aa [6];
    logic signed [35:0] r_as1 [3], r_as2 [3];
    logic signed [33:0] r_omc, r_c1, r_c2;
    logic signed [37:0] r_t [6];
    logic signed [31:0] r_m [9];
    logic signed [49:0] r_p [9];
    t_vec               r_vec1, r_vec2, r_vec3;
    t_res               r_res;

    logic signed [31:0] n_aa [6];
    logic signed [35:0] n_as [3];
    logic signed [37:0] n_t [6];
    logic signed [31:0] n_m [9];
    logic signed [49:0] n_p [9];
    t_res               n_res;

    assign en      = !i_full;
    assign o_pop   = en && i_valid;
    assign o_valid = r_v5;
    assign o_res   = r_res;

    // stage 1: axis products and axis times sine
    always_comb begin
        logic signed [49:0] pr;
        n_aa[P_XX] = i_item.axis.x * i_item.axis.x;
        n_aa[P_XY] = i_item.axis.x * i_item.axis.y;
        n_aa[P_XZ] = i_item.axis.x * i_item.axis.z;
        n_aa[P_YY] = i_item.axis.y * i_item.axis.y;
        n_aa[P_YZ] = i_item.axis.y * i_item.axis.z;
        n_aa[P_ZZ] = i_item.axis.z * i_item.axis.z;
        pr = i_item.axis.x * i_item.s;
        n_as[0] = 36'(pr >>> 14);
        pr = i_item.axis.y * i_item.s;
        n_as[1] = 36'(pr >>> 14);
        pr = i_item.axis.z * i_item.s;
        n_as[2] = 36'(pr >>> 14);
    end

    // stage 2: symmetric part scaled by one minus cosine
    always_comb begin
        logic signed [65:0] pr;
        for (int k = 0; k < 6; k++) begin
            pr = r_aa[k] * r_omc;
            n_t[k] = 38'(pr >>> 28);
        end
    end

    // stage 3: add diagonal cosine and skew sine terms, clip to [-2, 2)
    always_comb begin
        logic signed [38:0] c, a0, a1, a2;
        c  = 39'(r_c2);
        a0 = 39'(r_as2[0]);
        a1 = 39'(r_as2[1]);
        a2 = 39'(r_as2[2]);
        n_m[0] = sat_coef(39'(r_t[P_XX]) + c);
        n_m[1] = sat_coef(39'(r_t[P_XY]) - a2);
        n_m[2] = sat_coef(39'(r_t[P_XZ]) + a1);
        n_m[3] = sat_coef(39'(r_t[P_XY]) + a2);
        n_m[4] = sat_coef(39'(r_t[P_YY]) + c);
        n_m[5] = sat_coef(39'(r_t[P_YZ]) - a0);
        n_m[6] = sat_coef(39'(r_t[P_XZ]) - a1);
        n_m[7] = sat_coef(39'(r_t[P_YZ]) + a0);
        n_m[8] = sat_coef(39'(r_t[P_ZZ]) + c);
    end

    // stage 4: coefficient times vector component
    always_comb begin
        logic signed [63:0] pr;
        for (int r = 0; r < 3; r++) begin
            pr = r_m[3*r] * r_vec3.x;
            n_p[3*r] = 50'(pr >>> 14);
            pr = r_m[3*r+1] * r_vec3.y;
            n_p[3*r+1] = 50'(pr >>> 14);
            pr = r_m[3*r+2] * r_vec3.z;
            n_p[3*r+2] = 50'(pr >>> 14);
        end
    end

    // stage 5: row sums, round to Q16.16, saturate
    always_comb begin
        logic signed [51:0] sum;
        logic signed [35:0] q;
        logic signed [31:0] o [3];
        logic               sat;
        sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            sum = 52'(r_p[3*r]) + 52'(r_p[3*r+1]) + 52'(r_p[3*r+2]) + 52'sd32768;
            q   = 36'(sum >>> 16);
            if (q > 36'sd2147483647) begin
                o[r] = 32'sh7FFFFFFF;
                sat  = 1'b1;
            end else if (q < -36'sd2147483648) begin
                o[r] = 32'sh80000000;
                sat  = 1'b1;
            end else begin
                o[r] = q[31:0];
            end
        end
        n_res.vec.x = o[0];
        n_res.vec.y = o[1];
        n_res.vec.z = o[2];
        n_res.sat   = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aa   <= n_aa;
            r_as1  <= n_as;
            r_omc  <= ONE_Q30 - i_item.c;
            r_c1   <= i_item.c;
            r_vec1 <= i_item.vec;
            r_t    <= n_t;
            r_as2  <= r_as1;
            r_c2   <= r_c1;
            r_vec2 <= r_vec1;
            r_m    <= n_m;
            r_vec3 <= r_vec2;
            r_p    <= n_p;
            r_res  <= n_res;
        end
    end
endmodule

FILE: tb/sv/rotation_checker.sv
// Checker: predicts rotated vectors from accepted inputs and compares results.
`timescale 1ns / 100ps
module rotation_checker import aavr_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic        [15:0] turn_angle,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    input  logic               saturated,
    output int                 fail_count,
    output int                 pending
);

    t_res rotated_q[$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint axis_coef(longint ai, longint aj, longint omc, longint extra);
        return clip32(floor_shr(ai * aj * omc, 28) + extra);
    endfunction

    function automatic t_res rotate(t_vec v, t_axis a, logic [15:0] ang);
        logic [31:0] u;
        logic        flip;
        longint      x, y, z, dx, dy, c, s, omc;
        longint      vv[3], aa[3], as_[3], m[3][3], sum, r;
        t_res        res;
        u = {ang, 16'h0000};
        flip = 1'b0;
        z = longint'($signed(u));
        if (z >= 64'sh40000000 || z < -64'sh40000000) begin
            u = u + 32'h80000000;
            z = longint'($signed(u));
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        omc = 64'sd1073741824 - c;
        vv[0] = v.x; vv[1] = v.y; vv[2] = v.z;
        aa[0] = a.x; aa[1] = a.y; aa[2] = a.z;
        for (int k = 0; k < 3; k++) as_[k] = floor_shr(aa[k] * s, 14);
        m[0][0] = axis_coef(aa[0], aa[0], omc, c);
        m[0][1] = axis_coef(aa[0], aa[1], omc, -as_[2]);
        m[0][2] = axis_coef(aa[0], aa[2], omc, as_[1]);
        m[1][0] = axis_coef(aa[0], aa[1], omc, as_[2]);
        m[1][1] = axis_coef(aa[1], aa[1], omc, c);
        m[1][2] = axis_coef(aa[1], aa[2], omc, -as_[0]);
        m[2][0] = axis_coef(aa[0], aa[2], omc, -as_[1]);
        m[2][1] = axis_coef(aa[1], aa[2], omc, as_[0]);
        m[2][2] = axis_coef(aa[2], aa[2], omc, c);
        res.sat = 1'b0;
        for (int row = 0; row < 3; row++) begin
            sum = 0;
            for (int k = 0; k < 3; k++) sum += floor_shr(m[row][k] * vv[k], 14);
            r = floor_shr(sum + 32768, 16);
            if (r != clip32(r)) res.sat = 1'b1;
            r = clip32(r);
            case (row)
                0: res.vec.x = r[31:0];
                1: res.vec.y = r[31:0];
                default: res.vec.z = r[31:0];
            endcase
        end
        return res;
    endfunction

    initial fail_count = 0;
    assign pending = rotated_q.size();

    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && push && !full)
            rotated_q.push_back(rotate('{in_x, in_y, in_z}, '{axis_x, axis_y, axis_z},
                                       turn_angle));
        if (i_rst_n && pop && !empty) begin
            if (rotated_q.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                exp_r = rotated_q.pop_front();
                if (out_x !== exp_r.vec.x) begin
                    $error("out_x exp %0d got %0d", exp_r.vec.x, out_x); fail_count++;
                end
                if (out_y !== exp_r.vec.y) begin
                    $error("out_y exp %0d got %0d", exp_r.vec.y, out_y); fail_count++;
                end
                if (out_z !== exp_r.vec.z) begin
                    $error("out_z exp %0d got %0d", exp_r.vec.z, out_z); fail_count++;
                end
                if (saturated !== exp_r.sat) begin
                    $error("saturated exp %0b got %0b", exp_r.sat, saturated);
                    fail_count++;
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top: stimulus, receiver pacing, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
    import aavr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 1500;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               full, empty, o_saturated;
    logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
    logic signed [15:0] ax = '0, ay = '0, az = '0;
    logic        [15:0] ang = '0;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    int                 fail_count, pending;
    int                 idle_cycles = 0;
    bit                 quiet = 1'b0;
    bit                 hold_rx = 1'b0;

    always #5 i_clk = ~i_clk;

    axis_angle_vector_rotation dut (
        .i_clk, .i_rst_n, .push, .full,
        .i_in_x(in_x), .i_in_y(in_y), .i_in_z(in_z),
        .i_axis_x(ax), .i_axis_y(ay), .i_axis_z(az), .i_turn_angle(ang),
        .empty, .pop, .o_out_x, .o_out_y, .o_out_z, .o_saturated
    );

    rotation_checker chk (
        .i_clk, .i_rst_n, .push, .full,
        .in_x, .in_y, .in_z, .axis_x(ax), .axis_y(ay), .axis_z(az), .turn_angle(ang),
        .empty, .pop, .out_x(o_out_x), .out_y(o_out_y), .out_z(o_out_z),
        .saturated(o_saturated), .fail_count, .pending
    );

    // receiver: random stalls, plus a long hold-off
    always @(posedge i_clk) begin
        if (hold_rx) pop <= 1'b0;
        else pop <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_axis_part();
        case ($urandom_range(3))
            0: return 16'sd16384;
            1: return -16'sd16384;
            default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
        endcase
    endfunction

    // one transaction; push stays high across back-to-back items
    task automatic send(logic [31:0] x, y, z, logic [15:0] a0, a1, a2, t);
        while (!quiet && $urandom_range(99) < 7) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        in_x <= x; in_y <= y; in_z <= z;
        ax <= a0; ay <= a1; az <= a2; ang <= t;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_vec();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            default: return $signed(32'($urandom_range(2000000))) - 32'sd1000000;
        endcase
    endfunction

    initial begin
        logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h3FFF, 16'h8000, 16'hC000,
                                 16'hBFFF, 16'hFFFF, 16'h2000};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: angle quadrant edges on the x axis, then full-scale vectors
        foreach (angs[i]) send(32'h00010000, 32'h00020000, 32'hFFFF0000,
                               16'sd16384, 16'sd0, 16'sd0, angs[i]);
        send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd16384, 16'sd16384,
             16'sd16384, 16'h1000);
        send(32'h80000000, 32'h80000000, 32'h80000000, -16'sd16384, -16'sd16384,
             -16'sd16384, 16'hA000);
        send(32'h80000000, 32'h7FFFFFFF, 32'h0, 16'sd0, -16'sd16384, 16'sd0, 16'h6000);
        send(32'h12345678, 32'hFEDCBA98, 32'h0, 16'sd0, 16'sd0, 16'sd16384, 16'h4000);
        send(32'hFFFFFFFF, 32'h0, 32'h1, 16'sd11585, 16'sd11585, 16'sd0, 16'h8000);
        send(32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'h5555);
        // back pressure: receiver held off, sender keeps going until full
        hold_rx = 1'b1;
        fork
            begin repeat (200) @(posedge i_clk); hold_rx = 1'b0; end
            repeat (40) send(rand_vec(), rand_vec(), rand_vec(), rand_axis_part(),
                             rand_axis_part(), rand_axis_part(), 16'($urandom()));
        join
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 600 && n < 800);
            send(rand_vec(), rand_vec(), rand_vec(), rand_axis_part(),
                 rand_axis_part(), rand_axis_part(), 16'($urandom()));
        end
        quiet = 1'b0;
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: axis_angle_vector_rotation.f
hdl/aavr_pkg.sv
hdl/aavr_fifo.sv
hdl/aavr_front.sv
hdl/aavr_back.sv
hdl/axis_angle_vector_rotation.sv
tb/sv/rotation_checker.sv
tb/sv/tb_top.sv
